### hw/rtl/mctt_pkg.sv
// Package for the multi-channel tick timer.
// Opcodes, field widths and the result beat type; no dependencies.
package mctt_pkg;

    localparam int DEF_CHANNELS = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int TICK_W       = 32;
    localparam int OPC_W        = 2;
    localparam int CHAN_W       = 4;

    localparam logic [OPC_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPC_W-1:0] OP_START = 2'd1;
    localparam logic [OPC_W-1:0] OP_STOP  = 2'd2;

    typedef struct packed {
        logic              fired;
        logic [CHAN_W-1:0] fired_channel;
        logic [TICK_W-1:0] tick_now;
        logic              any_running;
        logic              last;
    } result_t;

endpackage

### hw/rtl/mctt_chan_mem.sv
// Channel store of the tick timer: stamp and period per channel.
// Simple dual-port RAM, registered read; uses mctt_pkg.
module mctt_chan_mem
    import mctt_pkg::*;
#(
    parameter int DEPTH = DEF_CHANNELS,
    parameter int AW    = 4
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [2*TICK_W-1:0]   wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [2*TICK_W-1:0]   rdata
);

    logic [2*TICK_W-1:0] mem [DEPTH];
    logic [2*TICK_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/mctt_out_stage.sv
// Result output register of the tick timer: holds one beat until taken.
// Uses mctt_pkg for the result type.
module mctt_out_stage
    import mctt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

### hw/rtl/multi_channel_tick_timer.sv
// Multi-channel tick timer: a bank of CHANNELS one-shot or periodic timers
// sharing one 32-bit tick counter. Each input beat is a tick, a start or a
// stop; afterwards every channel is scanned in index order and each channel
// that has expired gives one result beat (at most 16 per item), otherwise a
// single idle beat is sent. The final beat of an item carries last. Steps:
// capture, apply, first read, then one channel per cycle through the
// stamp/period RAM while a stalled result channel does not hold the scan,
// then the closing beat; the result limit can end the scan early. The next
// input beat is taken once the item's last result has been loaded into the
// output register.
// Stamps and periods live in RAM with no reset; running and mode bits are flops.
module multi_channel_tick_timer
    import mctt_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OPC_W-1:0]  s_opcode,
    input  logic [CHAN_W-1:0] s_channel,
    input  logic [TICK_W-1:0] s_period,
    input  logic              s_periodic,
    input  logic              s_only_if_idle,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_fired,
    output logic [CHAN_W-1:0] m_fired_channel,
    output logic [TICK_W-1:0] m_tick_now,
    output logic              m_any_running,
    output logic              m_last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // captured command
    logic [OPC_W-1:0]    op_reg, op_next;
    logic [CHAN_W-1:0]   ch_reg, ch_next;
    logic [TICK_W-1:0]   per_reg, per_next;
    logic                loop_reg, loop_next;
    logic                idle_only_reg, idle_only_next;

    // timer state held in flops
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CHANNELS-1:0] periodic_reg, periodic_next;

    // scan control
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    fire_cnt_reg, fire_cnt_next;

    // most recent fire, held back until we know whether it is the last beat
    logic                pend_valid_reg, pend_valid_next;
    logic [CHAN_W-1:0]   pend_ch_reg, pend_ch_next;
    logic                pend_any_reg, pend_any_next;

    // RAM ports
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [2*TICK_W-1:0] mem_wdata, mem_rdata;
    logic [TICK_W-1:0]   rd_stamp, rd_period;

    // output stage
    logic                out_push, out_free;
    result_t             out_data, m_data;

    // derived
    logic [IDX_W+3:0]    ch_ext, idx_ext;
    logic [IDX_W-1:0]    ch_idx;
    logic                ch_ok;
    logic [TICK_W-1:0]   elapsed;
    logic                fire, stall, done;
    logic [CHANNELS-1:0] run_after;

    assign ch_ext  = {{IDX_W{1'b0}}, ch_reg};
    assign ch_idx  = ch_ext[IDX_W-1:0];
    assign ch_ok   = ({28'd0, ch_reg} < 32'(CHANNELS));
    assign idx_ext = {4'd0, idx_reg};

    assign rd_stamp  = mem_rdata[2*TICK_W-1:TICK_W];
    assign rd_period = mem_rdata[TICK_W-1:0];
    assign elapsed   = tick_reg - rd_stamp;
    assign fire      = running_reg[idx_reg] && (elapsed >= rd_period);
    // a fire needs the output register only if an earlier fire is waiting
    assign stall     = fire && pend_valid_reg && !out_free;

    always_comb begin
        run_after = running_reg;
        if (!periodic_reg[idx_reg]) begin
            run_after[idx_reg] = 1'b0;
        end
    end

    assign done = (idx_reg == IDX_W'(CHANNELS - 1)) ||
                  (fire && ((fire_cnt_reg + 1'b1) == CNT_W'(MAX_RESULTS)));

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        per_next        = per_reg;
        loop_next       = loop_reg;
        idle_only_next  = idle_only_reg;
        tick_next       = tick_reg;
        running_next    = running_reg;
        periodic_next   = periodic_reg;
        idx_next        = idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_any_next   = pend_any_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = {tick_reg, rd_period};
        mem_re          = 1'b0;
        mem_raddr       = idx_reg + 1'b1;
        out_push        = 1'b0;
        out_data        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_opcode;
                    ch_next        = s_channel;
                    per_next       = s_period;
                    loop_next      = s_periodic;
                    idle_only_next = s_only_if_idle;
                    state_next     = ST_APPLY;
                end
            end
            ST_APPLY: begin
                case (op_reg)
                    OP_TICK: begin
                        tick_next = tick_reg + 1'b1;
                    end
                    OP_START: begin
                        if (ch_ok && !(idle_only_reg && running_reg[ch_idx])) begin
                            mem_we                = 1'b1;
                            mem_waddr             = ch_idx;
                            mem_wdata             = {tick_reg, per_reg};
                            running_next[ch_idx]  = 1'b1;
                            periodic_next[ch_idx] = loop_reg;
                        end
                    end
                    OP_STOP: begin
                        if (ch_ok) begin
                            running_next[ch_idx] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                fire_cnt_next   = '0;
                pend_valid_next = 1'b0;
                pend_ch_next    = '0;
                pend_any_next   = 1'b0;
                state_next      = ST_LOAD;
            end
            ST_LOAD: begin
                // read in the cycle after any start write, so channel 0 sees it
                mem_re     = 1'b1;
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (fire) begin
                        mem_we       = 1'b1;
                        running_next = run_after;
                        if (pend_valid_reg) begin
                            out_push               = 1'b1;
                            out_data.fired         = 1'b1;
                            out_data.fired_channel = pend_ch_reg;
                            out_data.tick_now      = tick_reg;
                            out_data.any_running   = pend_any_reg;
                            out_data.last          = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = idx_ext[3:0];
                        pend_any_next   = |run_after;
                        fire_cnt_next   = fire_cnt_reg + 1'b1;
                    end
                    if (done) begin
                        state_next = ST_FINISH;
                    end else begin
                        mem_re   = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_push               = 1'b1;
                    out_data.fired         = pend_valid_reg;
                    out_data.fired_channel = pend_valid_reg ? pend_ch_reg : '0;
                    out_data.tick_now      = tick_reg;
                    out_data.any_running   = pend_valid_reg ? pend_any_reg : |running_reg;
                    out_data.last          = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            running_reg    <= '0;
            periodic_reg   <= '0;
            idx_reg        <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            running_reg    <= running_next;
            periodic_reg   <= periodic_next;
            idx_reg        <= idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
        op_reg        <= op_next;
        ch_reg        <= ch_next;
        per_reg       <= per_next;
        loop_reg      <= loop_next;
        idle_only_reg <= idle_only_next;
        pend_ch_reg   <= pend_ch_next;
        pend_any_reg  <= pend_any_next;
    end

    assign s_ready = (state_reg == ST_IDLE);

    mctt_chan_mem #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mctt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_data (out_data),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_fired         = m_data.fired;
    assign m_fired_channel = m_data.fired_channel;
    assign m_tick_now      = m_data.tick_now;
    assign m_any_running   = m_data.any_running;
    assign m_last          = m_data.last;

    // no fire held back once an item is complete
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending fire left over in idle");

    // fire limit per item respected
    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("too many fires in one item");

    // an idle beat always closes its item
    a_idle_beat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_fired) |-> m_last)
        else $error("idle beat without last");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken during an item");

endmodule

### bench/multi_channel_tick_timer_tb.sv
// Self-checking bench for multi_channel_tick_timer: directed and random command beats,
// each predicted in the bench and checked against the result beats, field by field.
// Depends on mctt_pkg and the multi_channel_tick_timer RTL only.
module multi_channel_tick_timer_tb;
    import mctt_pkg::*;

    // opcode 3 is not defined by the block; it must change nothing
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    localparam int N_RANDOM   = 340;
    localparam int IDLE_PCT   = 23;
    // receiver back-pressure window, counted in receiver cycles after reset
    localparam int HOLD_AT    = 1500;
    localparam int HOLD_LEN   = 400;
    // both sides run flat out inside this window
    localparam int CALM_AT    = 3000;
    localparam int CALM_LEN   = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [CHAN_W-1:0] channel;
        logic [TICK_W-1:0] period;
        logic              periodic;
        logic              only_if_idle;
        logic              drain;      // hold this beat back until every result is in
    } timer_cmd_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OPC_W-1:0]  s_opcode       = '0;
    logic [CHAN_W-1:0] s_channel      = '0;
    logic [TICK_W-1:0] s_period       = '0;
    logic              s_periodic     = 1'b0;
    logic              s_only_if_idle = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_fired;
    logic [CHAN_W-1:0] m_fired_channel;
    logic [TICK_W-1:0] m_tick_now;
    logic              m_any_running;
    logic              m_last;

    always #10 aclk = ~aclk;

    multi_channel_tick_timer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_channel       (s_channel),
        .s_period        (s_period),
        .s_periodic      (s_periodic),
        .s_only_if_idle  (s_only_if_idle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fired         (m_fired),
        .m_fired_channel (m_fired_channel),
        .m_tick_now      (m_tick_now),
        .m_any_running   (m_any_running),
        .m_last          (m_last)
    );

    // ------------------------------------------------------------------
    // Timer state as the bench sees it
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]       tick_mirror;
    logic [DEF_CHANNELS-1:0] run_mirror;
    logic [DEF_CHANNELS-1:0] reload_mirror;
    logic [TICK_W-1:0]       stamp_mirror  [DEF_CHANNELS];
    logic [TICK_W-1:0]       period_mirror [DEF_CHANNELS];

    timer_cmd_t pending_cmds[$];   // beats still to be offered
    result_t    due_beats[$];      // predicted result beats, oldest first
    timer_cmd_t cur_cmd;           // beat currently on the input port
    result_t    want;

    int n_cmds;
    int fire_count;
    int items_taken = 0;           // updated with NBA only
    int beats_due   = 0;           // updated with NBA only
    int beats_seen  = 0;           // updated with NBA only
    int errors      = 0;
    int tx_cycle    = 0;
    int rx_cycle    = 0;

    // Apply one command, then scan the channels in index order as the block does.
    // Pushes the beats it causes and returns how many.
    task automatic scan_channels(input timer_cmd_t c, output int n);
        int          i;
        logic [31:0] elapsed;
        result_t     r;
        begin
            n = 0;
            case (c.opcode)
                OP_TICK: begin
                    tick_mirror = tick_mirror + 1'b1;
                end
                OP_START: begin
                    // only_if_idle leaves a running channel alone; a restart re-arms it
                    if (!(c.only_if_idle && run_mirror[c.channel])) begin
                        stamp_mirror[c.channel]  = tick_mirror;
                        period_mirror[c.channel] = c.period;
                        reload_mirror[c.channel] = c.periodic;
                        run_mirror[c.channel]    = 1'b1;
                    end
                end
                OP_STOP: begin
                    run_mirror[c.channel] = 1'b0;
                end
                default: ;
            endcase
            for (i = 0; i < DEF_CHANNELS && n < MAX_RESULTS; i++) begin
                elapsed = tick_mirror - stamp_mirror[i];
                if (run_mirror[i] && elapsed >= period_mirror[i]) begin
                    stamp_mirror[i] = tick_mirror;
                    if (!reload_mirror[i])
                        run_mirror[i] = 1'b0;
                    r.fired         = 1'b1;
                    r.fired_channel = i[CHAN_W-1:0];
                    r.tick_now      = tick_mirror;
                    r.any_running   = |run_mirror;
                    r.last          = 1'b0;
                    due_beats.push_back(r);
                    n++;
                end
            end
            // nothing expired: a single idle beat
            if (n == 0) begin
                r.fired         = 1'b0;
                r.fired_channel = '0;
                r.tick_now      = tick_mirror;
                r.any_running   = |run_mirror;
                r.last          = 1'b0;
                due_beats.push_back(r);
                n = 1;
            end
            r = due_beats.pop_back();
            r.last = 1'b1;
            due_beats.push_back(r);
        end
    endtask

    task automatic add_cmd(input logic [OPC_W-1:0] op, input logic [CHAN_W-1:0] ch,
                           input logic [TICK_W-1:0] per, input logic loop,
                           input logic idle_only, input logic drain);
        timer_cmd_t c;
        begin
            c.opcode       = op;
            c.channel      = ch;
            c.period       = per;
            c.periodic     = loop;
            c.only_if_idle = idle_only;
            c.drain        = drain;
            pending_cmds.push_back(c);
        end
    endtask

    // Random command: mostly ticks and starts with short periods so that channels
    // actually expire; now and then a full-width or near-maximum period, stops,
    // and the unused opcode. Fields a command ignores still get random noise.
    task automatic add_random_cmd(input logic drain);
        int                r;
        int                psel;
        logic [OPC_W-1:0]  op;
        logic [TICK_W-1:0] per;
        begin
            r    = $urandom_range(99);
            psel = $urandom_range(9);
            if (r < 45)
                op = OP_TICK;
            else if (r < 75)
                op = OP_START;
            else if (r < 92)
                op = OP_STOP;
            else
                op = OP_UNUSED;
            if (psel < 7)
                per = $urandom_range(8);
            else if (psel == 7)
                per = $urandom;
            else if (psel == 8)
                per = 32'hFFFF_FFFF - $urandom_range(3);
            else
                per = '0;
            add_cmd(op, CHAN_W'($urandom_range(DEF_CHANNELS - 1)), per,
                    1'($urandom_range(1)), ($urandom_range(3) == 0), drain);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        begin
            if (exp_v !== got_v) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, got_v);
                errors++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int k;
        tick_mirror   = '0;
        run_mirror    = '0;
        reload_mirror = '0;
        for (k = 0; k < DEF_CHANNELS; k++) begin
            stamp_mirror[k]  = '0;
            period_mirror[k] = '0;
        end

        // unused opcode with every field at its top value: no state change
        add_cmd(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        // stop of a channel that never ran
        add_cmd(OP_STOP, 4'd5, 32'h0, 1'b0, 1'b0, 1'b0);
        // one-shot with period zero fires on its own start and stops
        add_cmd(OP_START, 4'd0, 32'h0, 1'b0, 1'b1, 1'b0);
        // periodic at the largest period: stays quiet
        add_cmd(OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        // start with only_if_idle on a running channel is dropped
        add_cmd(OP_START, 4'd15, 32'd2, 1'b0, 1'b1, 1'b0);
        // restart of a running channel re-arms it
        add_cmd(OP_START, 4'd15, 32'd1, 1'b1, 1'b0, 1'b0);
        add_cmd(OP_TICK, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_cmd(OP_STOP, 4'd15, 32'h0, 1'b0, 1'b0, 1'b0);
        // arm every channel with period one, then a tick fires all sixteen
        for (k = 0; k < DEF_CHANNELS; k++)
            add_cmd(OP_START, k[CHAN_W-1:0], 32'd1, 1'b1, 1'b0, 1'b0);
        add_cmd(OP_TICK, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0);

        // sender pauses until all results are in at the start and middle of the random part
        for (k = 0; k < N_RANDOM; k++)
            add_random_cmd(k == 0 || k == N_RANDOM / 2);
        n_cmds = pending_cmds.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (items_taken != n_cmds || beats_seen != beats_due);
        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_beats.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, due_beats.size());
            errors++;
        end
        if (errors == 0) begin
            $display("multi_channel_tick_timer test passed");
        end else begin
            $display("multi_channel_tick_timer test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("multi_channel_tick_timer test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued command beats, predicting each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            tx_cycle <= 0;
        end else begin
            tx_cycle <= tx_cycle + 1;
            if (s_valid && s_ready) begin
                scan_channels(cur_cmd, fire_count);
                beats_due   <= beats_due + fire_count;
                items_taken <= items_taken + 1;
            end
            if (!s_valid || s_ready) begin
                // a drain beat waits for an empty input port and every result
                // of earlier beats, counted on both sides with NBA values
                if (pending_cmds.size() != 0
                    && ((tx_cycle >= CALM_AT && tx_cycle < CALM_AT + CALM_LEN)
                        || $urandom_range(99) >= IDLE_PCT)
                    && !(pending_cmds[0].drain && (s_valid || beats_due != beats_seen))) begin
                    cur_cmd         = pending_cmds.pop_front();
                    s_opcode       <= cur_cmd.opcode;
                    s_channel      <= cur_cmd.channel;
                    s_period       <= cur_cmd.period;
                    s_periodic     <= cur_cmd.periodic;
                    s_only_if_idle <= cur_cmd.only_if_idle;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, one long hold-off so the block backs up
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN)
                m_ready <= 1'b0;
            else if (rx_cycle >= CALM_AT && rx_cycle < CALM_AT + CALM_LEN)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen <= beats_seen + 1;
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got channel %0d tick %0d",
                         $time, m_fired_channel, m_tick_now);
                errors++;
            end else begin
                want = due_beats.pop_front();
                check_field("fired", 32'(want.fired), 32'(m_fired));
                check_field("fired_channel", 32'(want.fired_channel), 32'(m_fired_channel));
                check_field("tick_now", want.tick_now, m_tick_now);
                check_field("any_running", 32'(want.any_running), 32'(m_any_running));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

endmodule
